>>> rtl/fcca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared types, codes and helpers of the cluster allocation table core.
// ----------------------------------------------------------------------------
package fcca_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ENT_W       = 28;
    localparam int CNT_W       = 17;
    localparam int N_W         = ADDR_W + 1;
    localparam int TOT_W       = 16;
    localparam int FC_W        = 32;
    localparam int CMD_W       = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ENT_W-1:0] ENT_BAD  = 28'hFFFFFF7;
    localparam logic [ENT_W-1:0] EOC_LOW  = 28'hFFFFFF8;
    localparam logic [ENT_W-1:0] EOC_WR   = 28'hFFFFFFF;
    localparam logic [ENT_W-1:0] FIRST_CL = 28'd2;
    localparam logic [FC_W-1:0]  FC_UNKNOWN = 32'hFFFFFFFF;
    localparam logic [FC_W-1:0]  FC_SAT     = 32'hFFFFFFFE;
    localparam logic [TOT_W-1:0] TOTAL_RST  = 16'd65534;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_END     = 3'd4
    } t_status;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 4'd0,
        CMD_WRITE  = 4'd1,
        CMD_ALLOC  = 4'd2,
        CMD_FREE   = 4'd3,
        CMD_ACHAIN = 4'd4,
        CMD_FCHAIN = 4'd5,
        CMD_NEXT   = 4'd6,
        CMD_EXTEND = 4'd7,
        CMD_LENGTH = 4'd8,
        CMD_AT     = 4'd9
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL  = 2'd0,
        CFG_FCOUNT = 2'd1,
        CFG_HINT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_RD_EV, S_NX_EV, S_AL_START, S_AL_CHK,
        S_LINK, S_FC_RD, S_FC_EV, S_WK_CHK, S_WK_EV, S_DONE
    } t_state;

    typedef struct packed {
        logic [TOT_W-1:0] total;
        logic             fc_we;
        logic             hint_we;
        logic [FC_W-1:0]  data;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [ENT_W-1:0] cluster;
        logic [FC_W-1:0]  free_count;
    } t_result;

    function automatic logic [ENT_W-1:0] top_of(input logic [TOT_W-1:0] total);
        logic [ENT_W-1:0] t;
        t = ENT_W'(total) + ENT_W'(1);
        if (t > ENT_W'(TABLE_DEPTH - 1)) begin
            t = ENT_W'(TABLE_DEPTH - 1);
        end
        return t;
    endfunction

    function automatic logic is_valid(input logic [ENT_W-1:0] c,
                                      input logic [ENT_W-1:0] top);
        return (c >= FIRST_CL) && (c <= top);
    endfunction

endpackage
`default_nettype wire

>>> rtl/fcca_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcca_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fcca_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

>>> rtl/fcca_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcca_engine
// Command sequencer: one table access per cycle through a shared
// increment/compare unit for scans, chain walks and rollback.
// ----------------------------------------------------------------------------
module fcca_engine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fcca_pkg::t_cfg                  i_cfg,
    input  wire logic                            i_start,
    input  wire logic [fcca_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [fcca_pkg::ENT_W-1:0]      i_cluster,
    input  wire logic [fcca_pkg::ENT_W-1:0]      i_value,
    input  wire logic [fcca_pkg::CNT_W-1:0]      i_count,
    input  wire logic [fcca_pkg::ENT_W-1:0]      i_index,
    input  wire logic                            i_slot_free,
    output logic                                 o_ready,
    output fcca_pkg::t_result                    o_res,
    output logic                                 o_ram_we,
    output logic      [fcca_pkg::ADDR_W-1:0]     o_ram_addr,
    output logic      [fcca_pkg::ENT_W-1:0]      o_ram_wdata,
    input  wire logic [fcca_pkg::ENT_W-1:0]      i_ram_rdata
);
    import fcca_pkg::*;

    t_state           r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [ENT_W-1:0] r_cl, n_cl, r_val, n_val, r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ENT_W-1:0] r_cur, n_cur, r_start, n_start, r_prev, n_prev;
    logic [ENT_W-1:0] r_first, n_first, r_got, n_got, r_res, n_res;
    logic [ENT_W-1:0] r_hint, n_hint;
    logic [N_W-1:0]   r_n, n_n;
    logic [FC_W-1:0]  r_fc, n_fc;
    t_status          r_st, n_st;
    logic             r_rb, n_rb;
    logic [ADDR_W-1:0] r_clr, n_clr;

    logic [ENT_W-1:0] w_top, w_cur_inc, w_nxt;
    logic             w_cl_ok, w_ev_ok, w_find, w_fail_rb, w_free_hit;
    logic [FC_W-1:0]  w_fc_inc, w_fc_dec;
    logic [N_W-1:0]   w_n_inc;

    always_comb begin
        w_top      = top_of(i_cfg.total);
        w_cl_ok    = is_valid(r_cl, w_top);
        w_cur_inc  = (r_cur + ENT_W'(1) > w_top) ? FIRST_CL : r_cur + ENT_W'(1);
        w_ev_ok    = (i_ram_rdata != ENT_BAD) &&
                     ((i_ram_rdata >= EOC_LOW) || is_valid(i_ram_rdata, w_top));
        w_nxt      = (i_ram_rdata >= EOC_LOW) ? '0 : i_ram_rdata;
        w_find     = (r_cmd == CMD_AT);
        w_fail_rb  = (r_cmd == CMD_ACHAIN) && (r_n != '0);
        w_free_hit = (i_ram_rdata == '0);
        w_fc_inc   = (r_fc < FC_SAT) ? r_fc + FC_W'(1) : r_fc;
        w_fc_dec   = (r_fc != FC_UNKNOWN && r_fc != '0) ? r_fc - FC_W'(1) : r_fc;
        w_n_inc    = r_n + N_W'(1);
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd; n_cl = r_cl; n_val = r_val; n_idx = r_idx; n_cnt = r_cnt;
        n_cur = r_cur; n_start = r_start; n_prev = r_prev; n_first = r_first;
        n_got = r_got; n_res = r_res; n_hint = r_hint; n_n = r_n; n_fc = r_fc;
        n_st = r_st; n_rb = r_rb; n_clr = r_clr;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd; n_cl = i_cluster; n_val = i_value;
                    n_cnt = i_count; n_idx = i_index;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res = '0; n_st = ST_INVALID; n_n = '0; n_rb = 1'b0;
                n_cur = r_cl; n_prev = r_cl;
                n_state = S_DONE;
                case (t_cmd'(r_cmd))
                    CMD_READ:   if (w_cl_ok) n_state = S_RD_EV;
                    CMD_WRITE:  if (w_cl_ok) n_st = ST_OK;
                    CMD_ALLOC:  n_state = S_AL_START;
                    CMD_FREE: begin
                        if (w_cl_ok) begin
                            n_st = ST_OK;
                            n_fc = w_fc_inc;
                            if (r_cl < r_hint) n_hint = r_cl;
                        end
                    end
                    CMD_ACHAIN: if (r_cnt != '0) n_state = S_AL_START;
                    CMD_FCHAIN: if (w_cl_ok) n_state = S_FC_RD;
                    CMD_NEXT:   if (w_cl_ok) n_state = S_NX_EV;
                    CMD_EXTEND: if (w_cl_ok) n_state = S_AL_START;
                    CMD_LENGTH: if (w_cl_ok) n_state = S_WK_CHK;
                    CMD_AT:     if (w_cl_ok) n_state = S_WK_CHK;
                    default:    n_state = S_DONE;
                endcase
            end
            S_RD_EV: begin
                n_st = ST_OK; n_res = i_ram_rdata; n_state = S_DONE;
            end
            S_NX_EV: begin
                n_state = S_DONE;
                if (w_ev_ok) begin
                    n_st = ST_OK; n_res = w_nxt;
                end else begin
                    n_st = ST_CORRUPT;
                end
            end
            S_AL_START: begin
                if (is_valid(r_hint, w_top)) begin
                    n_cur = r_hint; n_start = r_hint; n_state = S_AL_CHK;
                end else if (w_fail_rb) begin
                    n_st = ST_INVALID; n_rb = 1'b1; n_cur = r_first; n_state = S_FC_RD;
                end else begin
                    n_st = ST_INVALID; n_state = S_DONE;
                end
            end
            S_AL_CHK: begin
                if (w_free_hit) begin
                    n_fc = w_fc_dec;
                    n_hint = w_cur_inc;
                    n_got = r_cur;
                    if (r_cmd == CMD_ALLOC) begin
                        n_st = ST_OK; n_res = r_cur; n_state = S_DONE;
                    end else if (r_cmd == CMD_ACHAIN && r_n == '0) begin
                        n_first = r_cur; n_prev = r_cur; n_n = N_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            n_st = ST_OK; n_res = r_cur; n_state = S_DONE;
                        end else begin
                            n_state = S_AL_START;
                        end
                    end else begin
                        n_state = S_LINK;
                    end
                end else if (w_cur_inc == r_start) begin
                    n_st = ST_NOSPACE;
                    if (w_fail_rb) begin
                        n_rb = 1'b1; n_cur = r_first; n_state = S_FC_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_cur = w_cur_inc;
                end
            end
            S_LINK: begin
                if (r_cmd == CMD_EXTEND) begin
                    n_st = ST_OK; n_res = r_got; n_state = S_DONE;
                end else begin
                    n_prev = r_got;
                    n_n = w_n_inc;
                    if ({1'b0, w_n_inc} == (CNT_W + 1)'(r_cnt)) begin
                        n_st = ST_OK; n_res = r_first; n_state = S_DONE;
                    end else begin
                        n_state = S_AL_START;
                    end
                end
            end
            S_FC_RD: n_state = S_FC_EV;
            S_FC_EV: begin
                if (!w_ev_ok) begin
                    if (!r_rb) n_st = ST_CORRUPT;
                    n_state = S_DONE;
                end else begin
                    n_fc = w_fc_inc;
                    if (r_cur < r_hint) n_hint = r_cur;
                    if (w_nxt == '0) begin
                        if (!r_rb) n_st = ST_OK;
                        n_state = S_DONE;
                    end else begin
                        n_cur = w_nxt; n_state = S_FC_RD;
                    end
                end
            end
            S_WK_CHK: begin
                if (w_find && ENT_W'(r_n) == r_idx) begin
                    n_st = ST_OK; n_res = r_cur; n_state = S_DONE;
                end else begin
                    if (!w_find) n_n = w_n_inc;
                    n_state = S_WK_EV;
                end
            end
            S_WK_EV: begin
                if (!w_ev_ok) begin
                    n_st = ST_CORRUPT; n_state = S_DONE;
                end else if (w_nxt == '0) begin
                    n_state = S_DONE;
                    if (w_find) begin
                        n_st = ST_END;
                    end else begin
                        n_st = ST_OK; n_res = ENT_W'(r_n);
                    end
                end else begin
                    n_cur = w_nxt;
                    if (w_find) n_n = w_n_inc;
                    if ((w_find ? w_n_inc : r_n) > N_W'(i_cfg.total)) begin
                        n_st = ST_CORRUPT; n_state = S_DONE;
                    end else begin
                        n_state = S_WK_CHK;
                    end
                end
            end
            S_DONE: if (i_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (i_cfg.fc_we) n_fc = i_cfg.data;
        if (i_cfg.hint_we) n_hint = ENT_W'(i_cfg.data[TOT_W-1:0]);
    end

    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_ram_we    = 1'b0;
        o_ram_addr  = r_cur[ADDR_W-1:0];
        o_ram_wdata = '0;
        o_res.valid      = (r_state == S_DONE);
        o_res.status     = r_st;
        o_res.cluster    = r_res;
        o_res.free_count = r_fc;
        case (r_state)
            S_CLEAR: begin
                o_ram_we = 1'b1; o_ram_addr = r_clr;
            end
            S_DEC: begin
                o_ram_addr = r_cl[ADDR_W-1:0];
                if (r_cmd == CMD_WRITE) begin
                    o_ram_we = w_cl_ok; o_ram_wdata = r_val;
                end else if (r_cmd == CMD_FREE) begin
                    o_ram_we = w_cl_ok;
                end
            end
            S_AL_START: o_ram_addr = r_hint[ADDR_W-1:0];
            S_AL_CHK: begin
                if (w_free_hit) begin
                    o_ram_we = 1'b1; o_ram_wdata = EOC_WR;
                end else begin
                    o_ram_addr = w_cur_inc[ADDR_W-1:0];
                end
            end
            S_LINK: begin
                o_ram_we = 1'b1; o_ram_addr = r_prev[ADDR_W-1:0]; o_ram_wdata = r_got;
            end
            S_FC_EV: o_ram_we = w_ev_ok;
            default: o_ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_hint  <= FIRST_CL;
            r_fc    <= FC_UNKNOWN;
            r_rb    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_hint  <= n_hint;
            r_fc    <= n_fc;
            r_rb    <= n_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_cl <= n_cl; r_val <= n_val; r_idx <= n_idx; r_cnt <= n_cnt;
        r_cur <= n_cur; r_start <= n_start; r_prev <= n_prev; r_first <= n_first;
        r_got <= n_got; r_res <= n_res; r_n <= n_n; r_st <= n_st;
    end

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !o_ready)
        else $error("engine still ready after taking a beat");
    a_res_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_st != ST_OK) |-> (r_res == '0))
        else $error("non-ok result carries a cluster");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AL_CHK) |-> is_valid(r_cur, w_top))
        else $error("allocation scan left the cluster range");
    a_fc_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_fc) != FC_UNKNOWN && !$past(i_cfg.fc_we))
        |-> (r_fc != FC_UNKNOWN))
        else $error("known free count turned unknown");

endmodule
`default_nettype wire

>>> rtl/fat_cluster_chain_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_core
// FAT32 style allocation table with next-fit allocation and chain walks.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       i_valid / o_ready      i_cmd i_cluster i_value i_count i_index
// out      source     o_valid / i_ready      o_status o_result_cluster o_free_count
// cfg      sink       i_cfg_we (no wait)     i_cfg_index i_cfg_data
//
// Write and free update the table entry in the decode state; read and next read
// one entry; alloc scans table entries from the hint, extend then also links the
// new cluster; alloc chain scans for each cluster and links every one after the
// first; free chain and length walk the chain link by link. All table accesses
// go through the single table port.
// After reset a clearing pass zeroes all TABLE_DEPTH (65536) table entries,
// with o_ready low. A finished beat waits in the output register while the
// next command is taken.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [fcca_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [fcca_pkg::ENT_W-1:0]          i_cluster,
    input  wire logic [fcca_pkg::ENT_W-1:0]          i_value,
    input  wire logic [fcca_pkg::CNT_W-1:0]          i_count,
    input  wire logic [fcca_pkg::ENT_W-1:0]          i_index,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic      [2:0]                          o_status,
    output logic      [fcca_pkg::ENT_W-1:0]          o_result_cluster,
    output logic      [fcca_pkg::FC_W-1:0]           o_free_count,
    input  wire logic                                i_cfg_we,
    input  wire logic [fcca_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fcca_pkg::FC_W-1:0]           i_cfg_data
);
    import fcca_pkg::*;

    logic [TOT_W-1:0]  r_total;
    t_cfg              w_cfg;
    t_result           w_res;
    logic              w_slot_free, w_start;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_addr;
    logic [ENT_W-1:0]  w_ram_wdata, w_ram_rdata;

    always_comb begin
        w_cfg.total   = r_total;
        w_cfg.fc_we   = i_cfg_we && (i_cfg_index == CFG_FCOUNT);
        w_cfg.hint_we = i_cfg_we && (i_cfg_index == CFG_HINT);
        w_cfg.data    = i_cfg_data;
        w_slot_free   = !o_valid || i_ready;
        w_start       = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RST;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_TOTAL) begin
                r_total <= i_cfg_data[TOT_W-1:0];
            end
            if (w_slot_free) begin
                o_valid <= w_res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res.valid) begin
            o_status         <= w_res.status;
            o_result_cluster <= w_res.cluster;
            o_free_count     <= w_res.free_count;
        end
    end

    fcca_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    fcca_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_start     (w_start),
        .i_cmd       (i_cmd),
        .i_cluster   (i_cluster),
        .i_value     (i_value),
        .i_count     (i_count),
        .i_index     (i_index),
        .i_slot_free (w_slot_free),
        .o_ready     (o_ready),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_addr  (w_ram_addr),
        .o_ram_wdata (w_ram_wdata),
        .i_ram_rdata (w_ram_rdata)
    );

endmodule
`default_nettype wire
